// ----- design/isr_pkg.sv -----
// Shared types and constants for the ID slot registry table.
`timescale 1ns / 1ps
`default_nettype none

package isr_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int COUNT_OUT_W     = 7;

    typedef enum logic [2:0] {
        MODE_CLEAR      = 3'd0,
        MODE_REGISTER   = 3'd1,
        MODE_UNREGISTER = 3'd2,
        MODE_CONTAINS   = 3'd3,
        MODE_FIND_ID    = 3'd4,
        MODE_FIND_SPACE = 3'd5
    } isr_mode_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NOT_READY  = 3'd1,
        STAT_DUPLICATE  = 3'd2,
        STAT_BAD_ID     = 3'd3,
        STAT_TERMINATED = 3'd4,
        STAT_SLOT_TAKEN = 3'd5,
        STAT_NOT_OWNER  = 3'd6,
        STAT_UNDERFLOW  = 3'd7
    } isr_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_SCAN,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } isr_state_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] handle;
        logic [15:0] ident;
        logic        is_terminated;
        logic [63:0] space_tag;
    } isr_req_t;

    typedef struct packed {
        logic [2:0]             status;
        logic                   found;
        logic [31:0]            found_handle;
        logic [COUNT_OUT_W-1:0] entry_count;
    } isr_rsp_t;

    typedef struct packed {
        logic [31:0] owner;
        logic [63:0] space;
    } isr_slot_t;

    typedef struct packed {
        logic owner_eq;
        logic owner_nz;
        logic space_hit;
    } isr_cmp_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } isr_mem_ctl_t;

endpackage

`default_nettype wire

// ----- design/isr_slot_mem.sv -----
// Slot memory: owner handle and space tag per slot, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module isr_slot_mem #(
    parameter int DEPTH = isr_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = 6
) (
    input  wire                  clk,
    input  isr_pkg::isr_mem_ctl_t ctl,
    input  wire [AW-1:0]         wr_addr,
    input  isr_pkg::isr_slot_t   wr_data,
    input  wire [AW-1:0]         rd_addr,
    output isr_pkg::isr_slot_t   rd_data
);

    isr_pkg::isr_slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/isr_cmp_unit.sv -----
// Shared compare unit: matches one slot read against the request handle and tag.
`timescale 1ns / 1ps
`default_nettype none

module isr_cmp_unit (
    input  isr_pkg::isr_slot_t slot,
    input  wire [31:0]         key_handle,
    input  wire [63:0]         key_tag,
    output isr_pkg::isr_cmp_t  cmp
);

    always_comb
    begin
        cmp.owner_eq  = (slot.owner == key_handle);
        cmp.owner_nz  = (slot.owner != 32'd0);
        // Empty slots and a zero tag never match.
        cmp.space_hit = cmp.owner_nz && (key_tag != 64'd0) && (slot.space == key_tag);
    end

endmodule

`default_nettype wire

// ----- design/isr_seq.sv -----
// Command sequencer: decodes a request, drives slot sweeps and lookups, builds the result.
`timescale 1ns / 1ps
`default_nettype none

module isr_seq #(
    parameter int MAX_ENTRIES = isr_pkg::MAX_ENTRIES_DEF,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  isr_pkg::isr_req_t     req_in,
    input  wire                   take,
    input  isr_pkg::isr_cmp_t     cmp,
    input  isr_pkg::isr_slot_t    rd_slot,
    output logic                  idle,
    output logic                  done,
    output isr_pkg::isr_rsp_t     res,
    output isr_pkg::isr_req_t     cur_req,
    output isr_pkg::isr_mem_ctl_t mem_ctl,
    output logic [AW-1:0]         wr_addr,
    output isr_pkg::isr_slot_t    wr_data,
    output logic [AW-1:0]         rd_addr
);

    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ENTRIES - 1);

    isr_pkg::isr_state_t  state_reg, state_next;
    isr_pkg::isr_req_t    req_reg, req_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [AW-1:0]        chk_idx_reg, chk_idx_next;
    logic                 occ_reg, occ_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 ready_reg, ready_next;
    isr_pkg::isr_status_t status_reg, status_next;
    logic                 found_reg, found_next;
    logic [31:0]          fh_reg, fh_next;

    isr_pkg::isr_mode_t   mode;
    logic [15:0]          id_m1;
    logic [AW-1:0]        tgt;
    logic                 id_ok;
    logic                 null_h;
    logic                 occ_now;
    logic [31:0]          count_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= isr_pkg::ST_IDLE;
            issue_done_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            count_reg      <= '0;
            ready_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            chk_vld_reg    <= chk_vld_next;
            count_reg      <= count_next;
            ready_reg      <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        occ_reg     <= occ_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        fh_reg      <= fh_next;
    end

    assign mode   = isr_pkg::isr_mode_t'(req_reg.mode);
    assign id_m1  = req_reg.ident - 16'd1;
    assign tgt    = id_m1[AW-1:0];
    assign id_ok  = (req_reg.ident != 16'd0) && (req_reg.ident <= 16'(MAX_ENTRIES));
    assign null_h = (req_reg.handle == 32'd0);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        occ_next        = occ_reg;
        count_next      = count_reg;
        ready_next      = ready_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        fh_next         = fh_reg;
        occ_now         = occ_reg;
        mem_ctl         = '0;
        wr_addr         = idx_reg;
        wr_data.owner   = 32'd0;
        wr_data.space   = req_reg.space_tag;
        rd_addr         = idx_reg;
        idle            = 1'b0;
        done            = 1'b0;

        case (state_reg)
            isr_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    req_next   = req_in;
                    state_next = isr_pkg::ST_DECODE;
                end
            end

            isr_pkg::ST_DECODE:
            begin
                status_next     = isr_pkg::STAT_OK;
                found_next      = 1'b0;
                fh_next         = 32'd0;
                idx_next        = '0;
                issue_done_next = 1'b0;
                occ_next        = 1'b0;
                case (mode)
                    isr_pkg::MODE_CLEAR:
                    begin
                        state_next = isr_pkg::ST_CLEAR;
                    end
                    isr_pkg::MODE_REGISTER:
                    begin
                        if (!ready_reg || null_h)
                        begin
                            status_next = isr_pkg::STAT_NOT_READY;
                            state_next  = isr_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = isr_pkg::ST_SCAN;
                        end
                    end
                    isr_pkg::MODE_UNREGISTER, isr_pkg::MODE_CONTAINS:
                    begin
                        if (!ready_reg || null_h)
                        begin
                            status_next = isr_pkg::STAT_NOT_READY;
                            state_next  = isr_pkg::ST_DONE;
                        end
                        else if (!id_ok)
                        begin
                            status_next = isr_pkg::STAT_BAD_ID;
                            state_next  = isr_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = isr_pkg::ST_READ;
                        end
                    end
                    isr_pkg::MODE_FIND_ID:
                    begin
                        if (!ready_reg)
                        begin
                            status_next = isr_pkg::STAT_NOT_READY;
                            state_next  = isr_pkg::ST_DONE;
                        end
                        else if (!id_ok)
                        begin
                            status_next = isr_pkg::STAT_BAD_ID;
                            state_next  = isr_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = isr_pkg::ST_READ;
                        end
                    end
                    isr_pkg::MODE_FIND_SPACE:
                    begin
                        if (!ready_reg)
                        begin
                            status_next = isr_pkg::STAT_NOT_READY;
                            state_next  = isr_pkg::ST_DONE;
                        end
                        else if (req_reg.space_tag == 64'd0)
                        begin
                            state_next = isr_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = isr_pkg::ST_SCAN;
                        end
                    end
                    default:
                    begin
                        status_next = isr_pkg::STAT_NOT_READY;
                        state_next  = isr_pkg::ST_DONE;
                    end
                endcase
            end

            isr_pkg::ST_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    count_next = '0;
                    ready_next = 1'b1;
                    state_next = isr_pkg::ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            isr_pkg::ST_SCAN:
            begin
                // Issue one slot read per cycle; check it in the next cycle.
                if (!issue_done_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = idx_reg;
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = idx_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                if (chk_vld_reg)
                begin
                    if (mode == isr_pkg::MODE_REGISTER)
                    begin
                        occ_now  = occ_reg || (id_ok && (chk_idx_reg == tgt) && cmp.owner_nz);
                        occ_next = occ_now;
                        if (cmp.owner_eq)
                        begin
                            status_next = isr_pkg::STAT_DUPLICATE;
                            state_next  = isr_pkg::ST_DONE;
                        end
                        else if (chk_idx_reg == LAST_IDX)
                        begin
                            state_next = isr_pkg::ST_DONE;
                            if (!id_ok)
                            begin
                                status_next = isr_pkg::STAT_BAD_ID;
                            end
                            else if (req_reg.is_terminated)
                            begin
                                status_next = isr_pkg::STAT_TERMINATED;
                            end
                            else if (occ_now)
                            begin
                                status_next = isr_pkg::STAT_SLOT_TAKEN;
                            end
                            else
                            begin
                                mem_ctl.wr_en = 1'b1;
                                wr_addr       = tgt;
                                wr_data.owner = req_reg.handle;
                                count_next    = count_reg + CW'(1);
                            end
                        end
                    end
                    else
                    begin
                        if (cmp.space_hit)
                        begin
                            found_next = 1'b1;
                            fh_next    = rd_slot.owner;
                            state_next = isr_pkg::ST_DONE;
                        end
                        else if (chk_idx_reg == LAST_IDX)
                        begin
                            state_next = isr_pkg::ST_DONE;
                        end
                    end
                end
                if (state_next != isr_pkg::ST_SCAN)
                begin
                    chk_vld_next = 1'b0;
                end
            end

            isr_pkg::ST_READ:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = tgt;
                state_next    = isr_pkg::ST_CHECK;
            end

            isr_pkg::ST_CHECK:
            begin
                state_next = isr_pkg::ST_DONE;
                case (mode)
                    isr_pkg::MODE_UNREGISTER:
                    begin
                        if (!cmp.owner_eq)
                        begin
                            status_next = isr_pkg::STAT_NOT_OWNER;
                        end
                        else if (count_reg == '0)
                        begin
                            status_next = isr_pkg::STAT_UNDERFLOW;
                        end
                        else
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = tgt;
                            count_next    = count_reg - CW'(1);
                        end
                    end
                    isr_pkg::MODE_CONTAINS:
                    begin
                        found_next = cmp.owner_eq;
                        fh_next    = cmp.owner_eq ? req_reg.handle : 32'd0;
                    end
                    isr_pkg::MODE_FIND_ID:
                    begin
                        found_next = cmp.owner_nz;
                        fh_next    = rd_slot.owner;
                    end
                    default:
                    begin
                        status_next = isr_pkg::STAT_NOT_READY;
                    end
                endcase
            end

            isr_pkg::ST_DONE:
            begin
                done = 1'b1;
                if (take)
                begin
                    state_next = isr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = isr_pkg::ST_IDLE;
            end
        endcase
    end

    assign count_ext        = 32'(count_reg);
    assign res.status       = status_reg;
    assign res.found        = found_reg;
    assign res.found_handle = fh_reg;
    assign res.entry_count  = count_ext[isr_pkg::COUNT_OUT_W-1:0];
    assign cur_req          = req_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= 32'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_no_write_idle : assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> (state_reg == isr_pkg::ST_CLEAR || state_reg == isr_pkg::ST_SCAN ||
                           state_reg == isr_pkg::ST_CHECK))
        else $error("slot write outside a command");

    a_clear_result : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isr_pkg::ST_CLEAR && state_next == isr_pkg::ST_DONE)
        |=> (count_reg == '0 && ready_reg && status_reg == isr_pkg::STAT_OK))
        else $error("clear did not empty the table");

    a_not_ready_fails : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isr_pkg::ST_DONE && !ready_reg) |-> (status_reg != isr_pkg::STAT_OK))
        else $error("command succeeded before first clear");

    a_no_hit_no_handle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isr_pkg::ST_DONE && !found_reg) |-> (fh_reg == 32'd0))
        else $error("handle reported without a hit");

endmodule

`default_nettype wire

// ----- design/id_slot_registry_table_core.sv -----
// Top level of the ID slot registry table: sequencer, compare unit, slot memory, result register.
`timescale 1ns / 1ps
`default_nettype none

// A table of MAX_ENTRIES slots indexed by ident minus one; each slot holds an owner
// handle (zero means empty) and the space tag captured at registration. One request
// is taken at a time and answered with exactly one response. A request is accepted
// while the sequencer is idle, even if the previous response still waits in the
// output register. Work per request until the next request can be accepted (the
// response is loaded into the output register as the sequencer returns to idle):
//   - requests that fail in decode (not ready, null handle on register, unregister or
//     contains, bad ident on unregister, contains or find by id, unused mode) and find
//     by space with a zero tag: decode only
//   - unregister, contains, find by id: one slot read, one compare
//   - clear: the whole table, one slot zeroed per cycle through the write port
//   - register: a sweep of the whole table, bad ident, terminated object and taken
//     slot included, stopping early only when a duplicate handle is found
//   - find by space: a sweep of the table, stopping at the first hit
// The sweeps are bound by the single read port of the slot memory: one slot is read
// and checked by the shared compare unit per cycle. Until the first clear every
// command but clear fails with status 1 and the memory contents are never looked at,
// so reset needs no clearing pass; clear itself sweeps the whole table.

module id_slot_registry_table_core #(
    parameter int MAX_ENTRIES = isr_pkg::MAX_ENTRIES_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_stall,
    input  isr_pkg::isr_req_t req,
    output logic              rsp_valid,
    input  wire               rsp_stall,
    output isr_pkg::isr_rsp_t rsp
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic                  seq_idle;
    logic                  seq_done;
    logic                  start;
    logic                  take;
    isr_pkg::isr_rsp_t     res;
    isr_pkg::isr_req_t     cur_req;
    isr_pkg::isr_cmp_t     cmp;
    isr_pkg::isr_slot_t    rd_slot;
    isr_pkg::isr_slot_t    wr_data;
    isr_pkg::isr_mem_ctl_t mem_ctl;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;

    logic                  rsp_valid_reg, rsp_valid_next;
    isr_pkg::isr_rsp_t     rsp_reg;

    // Take a request only while the sequencer sits idle.
    assign req_stall = !seq_idle;
    assign start     = req_valid && seq_idle;

    // Move the finished response into the output register once it is free or draining.
    assign take = seq_done && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the payload while stalled; load only on a transfer.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    isr_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req_in  (req),
        .take    (take),
        .cmp     (cmp),
        .rd_slot (rd_slot),
        .idle    (seq_idle),
        .done    (seq_done),
        .res     (res),
        .cur_req (cur_req),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr)
    );

    // One compare unit serves the duplicate scan, the space search and single lookups.
    isr_cmp_unit u_cmp (
        .slot       (rd_slot),
        .key_handle (cur_req.handle),
        .key_tag    (cur_req.space_tag),
        .cmp        (cmp)
    );

    isr_slot_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_slot)
    );

endmodule

`default_nettype wire

// ----- bench/tb_id_slot_registry_table_core.sv -----
// Self-checking testbench for the ID slot registry table core.
`timescale 1ns / 1ps

module tb_id_slot_registry_table_core;

    import isr_pkg::*;

    localparam int ENTRIES = MAX_ENTRIES_DEF;

    // Modes 6 and 7 are not decoded by the block; they must come back as status 1.
    localparam logic [2:0] MODE_RSVD_A = 3'd6;
    localparam logic [2:0] MODE_RSVD_B = 3'd7;

    localparam int RANDOM_ITEMS = 700;
    // Early random requests lean on registration so the table fills toward all 64 slots.
    localparam int FILL_ITEMS   = 300;
    // Hold both sides free of idling over the tail of the run.
    localparam int QUIET_ITEMS  = 80;
    localparam int HANDLE_POOL  = 96;
    localparam int TAG_POOL     = 6;
    // The slowest command (register) sweeps the whole table; leave room for a stray response.
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
    // The limit leaves room for the slowest legal run even with stalls on both sides.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 100;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    isr_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    isr_rsp_t rsp;

    bit          quiet_tail = 1'b0;
    int unsigned cycle_count = 0;
    int          stall_left = 0;

    logic [31:0] handle_pool [HANDLE_POOL];
    logic [63:0] tag_pool [TAG_POOL];

    // Tracks the registry contents and queues the answer each accepted request must produce.
    class registry_scoreboard;
        logic [31:0] owner_of [ENTRIES];
        logic [63:0] tag_of [ENTRIES];
        logic [6:0]  live;
        bit          ready;
        isr_rsp_t    pending_answers[$];
        int unsigned mismatches;

        function new();
            foreach (owner_of[i]) owner_of[i] = '0;
            foreach (tag_of[i]) tag_of[i] = '0;
            live = '0;
            ready = 1'b0;
            mismatches = 0;
        endfunction

        function void note_request(isr_req_t r);
            isr_rsp_t    ans;
            isr_status_t st;
            bit          id_ok;
            bit          dup;
            int          slot;
            ans = '0;
            st = STAT_OK;
            id_ok = (r.ident >= 16'd1) && (r.ident <= 16'(ENTRIES));
            dup = 1'b0;
            slot = int'(r.ident) - 1;
            case (r.mode)
                MODE_CLEAR: begin
                    foreach (owner_of[i]) owner_of[i] = '0;
                    live = '0;
                    ready = 1'b1;
                end
                MODE_REGISTER: begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (owner_of[i] == r.handle) dup = 1'b1;
                    if (!ready || r.handle == '0) st = STAT_NOT_READY;
                    else if (dup) st = STAT_DUPLICATE;
                    else if (!id_ok) st = STAT_BAD_ID;
                    else if (r.is_terminated) st = STAT_TERMINATED;
                    else if (owner_of[slot] != '0) st = STAT_SLOT_TAKEN;
                    else
                    begin
                        owner_of[slot] = r.handle;
                        tag_of[slot] = r.space_tag;
                        live++;
                    end
                end
                MODE_UNREGISTER: begin
                    if (!ready || r.handle == '0) st = STAT_NOT_READY;
                    else if (!id_ok) st = STAT_BAD_ID;
                    else if (owner_of[slot] != r.handle) st = STAT_NOT_OWNER;
                    else if (live == '0) st = STAT_UNDERFLOW;
                    else
                    begin
                        owner_of[slot] = '0;
                        live--;
                    end
                end
                MODE_CONTAINS: begin
                    if (!ready || r.handle == '0) st = STAT_NOT_READY;
                    else if (!id_ok) st = STAT_BAD_ID;
                    else if (owner_of[slot] == r.handle)
                    begin
                        ans.found = 1'b1;
                        ans.found_handle = r.handle;
                    end
                end
                MODE_FIND_ID: begin
                    if (!ready) st = STAT_NOT_READY;
                    else if (!id_ok) st = STAT_BAD_ID;
                    else
                    begin
                        ans.found_handle = owner_of[slot];
                        ans.found = owner_of[slot] != '0;
                    end
                end
                MODE_FIND_SPACE: begin
                    if (!ready) st = STAT_NOT_READY;
                    else if (r.space_tag != '0)
                    begin
                        // Lowest occupied slot with a matching tag wins.
                        for (int i = ENTRIES - 1; i >= 0; i--)
                        begin
                            if (owner_of[i] != '0 && tag_of[i] == r.space_tag)
                            begin
                                ans.found = 1'b1;
                                ans.found_handle = owner_of[i];
                            end
                        end
                    end
                end
                default: st = STAT_NOT_READY;
            endcase
            ans.status = st;
            ans.entry_count = live;
            pending_answers.push_back(ans);
        endfunction

        function void check_response(isr_rsp_t got);
            isr_rsp_t want;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected response, expected none, got %h", $time, got);
                return;
            end
            want = pending_answers.pop_front();
            if (got.status !== want.status || got.found !== want.found ||
                got.found_handle !== want.found_handle ||
                got.entry_count !== want.entry_count)
            begin
                mismatches++;
                // Cap the report so a broken build does not flood the log.
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: expected status %0d found %0d handle %h count %0d,",
                             $time, want.status, want.found, want.found_handle,
                             want.entry_count,
                             " actual status %0d found %0d handle %h count %0d",
                             got.status, got.found, got.found_handle, got.entry_count);
            end
        endfunction
    endclass

    registry_scoreboard sb = new();

    id_slot_registry_table_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bail out if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Response side: check on each accepted response, then decide on the next stall.
    // Values read here are the ones the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            // Start a stall burst; stall_left counts the stalled cycles still to come.
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    function automatic isr_req_t make_request(logic [2:0] mode, logic [31:0] handle,
                                              logic [15:0] ident, logic term,
                                              logic [63:0] tag);
        isr_req_t r;
        r.mode = mode;
        r.handle = handle;
        r.ident = ident;
        r.is_terminated = term;
        r.space_tag = tag;
        return r;
    endfunction

    // Mostly well-formed requests built around the current table contents,
    // with null handles, bad idents and stray tags mixed in.
    function automatic isr_req_t random_request(bit fill_phase);
        isr_req_t r;
        int       pick;
        int       start;
        int       s;
        r.handle = handle_pool[$urandom_range(0, HANDLE_POOL - 1)];
        r.ident = 16'($urandom_range(1, ENTRIES));
        r.is_terminated = ($urandom_range(0, 9) == 0);
        r.space_tag = tag_pool[$urandom_range(0, TAG_POOL - 1)];
        pick = $urandom_range(0, 99);
        if (fill_phase)
        begin
            if (pick < 60) r.mode = MODE_REGISTER;
            else if (pick < 70) r.mode = MODE_UNREGISTER;
            else if (pick < 78) r.mode = MODE_CONTAINS;
            else if (pick < 86) r.mode = MODE_FIND_ID;
            else if (pick < 96) r.mode = MODE_FIND_SPACE;
            else r.mode = $urandom_range(0, 1) ? MODE_RSVD_A : MODE_RSVD_B;
        end
        else
        begin
            if (pick < 3) r.mode = MODE_CLEAR;
            else if (pick < 30) r.mode = MODE_REGISTER;
            else if (pick < 50) r.mode = MODE_UNREGISTER;
            else if (pick < 62) r.mode = MODE_CONTAINS;
            else if (pick < 74) r.mode = MODE_FIND_ID;
            else if (pick < 92) r.mode = MODE_FIND_SPACE;
            else r.mode = $urandom_range(0, 1) ? MODE_RSVD_A : MODE_RSVD_B;
        end

        // Aim unregister and contains at a live slot and its real owner most of the time.
        if ((r.mode == MODE_UNREGISTER || r.mode == MODE_CONTAINS) &&
            sb.live != '0 && $urandom_range(0, 9) < 7)
        begin
            start = $urandom_range(0, ENTRIES - 1);
            for (int k = ENTRIES - 1; k >= 0; k--)
            begin
                s = (start + k) % ENTRIES;
                if (sb.owner_of[s] != '0)
                begin
                    r.ident = 16'(s + 1);
                    r.handle = sb.owner_of[s];
                end
            end
        end

        pick = $urandom_range(0, 99);
        if (pick < 6) r.handle = '0;
        else if (pick < 12) r.handle = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 8) r.ident = 16'($urandom_range(0, 65535));
        else if (pick < 10) r.ident = '0;
        else if (pick < 12) r.ident = 16'(ENTRIES + 1);
        pick = $urandom_range(0, 99);
        if (pick < 10) r.space_tag = {$urandom, $urandom};
        else if (pick < 14) r.space_tag = '0;
        return r;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input isr_req_t r);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall !== 1'b0);
        sb.note_request(r);
    endtask

    initial
    begin
        isr_req_t directed[$];
        // Distinct, nonzero handles: the low half carries the pool index.
        for (int i = 0; i < HANDLE_POOL; i++)
            handle_pool[i] = {16'($urandom_range(1, 16'hFFFF)), 16'(i)};
        for (int i = 0; i < TAG_POOL; i++)
            tag_pool[i] = {$urandom, $urandom} | 64'd1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before the first clear everything fails.
        directed.push_back(make_request(MODE_REGISTER, 32'd5, 16'd1, 1'b0, 64'd1));
        directed.push_back(make_request(MODE_FIND_SPACE, 32'd5, 16'd1, 1'b0, 64'd1));
        directed.push_back(make_request(MODE_FIND_ID, 32'd5, 16'd1, 1'b0, 64'd1));
        directed.push_back(make_request(MODE_CLEAR, '0, '0, 1'b0, '0));
        // Register at both ends of the ident range, then each rejection in order.
        directed.push_back(make_request(MODE_REGISTER, '1, 16'(ENTRIES), 1'b0, '1));
        directed.push_back(make_request(MODE_REGISTER, 32'd1, 16'd1, 1'b0, 64'hA5));
        directed.push_back(make_request(MODE_REGISTER, 32'd1, 16'd2, 1'b0, 64'hA5));
        directed.push_back(make_request(MODE_REGISTER, '0, 16'd2, 1'b0, 64'hA5));
        directed.push_back(make_request(MODE_REGISTER, 32'd7, 16'd0, 1'b0, 64'hA5));
        directed.push_back(make_request(MODE_REGISTER, 32'd7, '1, 1'b0, 64'hA5));
        directed.push_back(make_request(MODE_REGISTER, 32'd7, 16'(ENTRIES + 1), 1'b0, '0));
        directed.push_back(make_request(MODE_REGISTER, 32'd7, 16'd3, 1'b1, 64'hA5));
        directed.push_back(make_request(MODE_REGISTER, 32'd7, 16'd1, 1'b0, 64'hA5));
        // Same tag in a higher slot: the search must report the lower one.
        directed.push_back(make_request(MODE_REGISTER, 32'd9, 16'd3, 1'b0, 64'hA5));
        directed.push_back(make_request(MODE_FIND_SPACE, '0, '0, 1'b0, 64'hA5));
        directed.push_back(make_request(MODE_FIND_SPACE, '1, '1, 1'b1, '0));
        directed.push_back(make_request(MODE_FIND_SPACE, '0, '0, 1'b0, '1));
        // Find by id ignores the handle, null or not.
        directed.push_back(make_request(MODE_FIND_ID, '0, 16'(ENTRIES), 1'b0, '0));
        directed.push_back(make_request(MODE_FIND_ID, '1, 16'd5, 1'b0, '0));
        directed.push_back(make_request(MODE_FIND_ID, '1, '1, 1'b0, '0));
        directed.push_back(make_request(MODE_CONTAINS, 32'd1, 16'd1, 1'b0, '0));
        directed.push_back(make_request(MODE_CONTAINS, 32'd9, 16'd1, 1'b0, '0));
        directed.push_back(make_request(MODE_CONTAINS, '0, 16'd1, 1'b0, '0));
        directed.push_back(make_request(MODE_UNREGISTER, 32'd9, 16'd1, 1'b0, '0));
        directed.push_back(make_request(MODE_UNREGISTER, 32'd1, 16'd1, 1'b0, '0));
        directed.push_back(make_request(MODE_RSVD_A, 32'd9, 16'd3, 1'b0, 64'hA5));
        directed.push_back(make_request(MODE_RSVD_B, '1, '1, 1'b1, '1));
        foreach (directed[i])
            send_request(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Drain everything once before the mixed phase starts.
            if (n == FILL_ITEMS)
            begin
                req_valid <= 1'b0;
                while (sb.pending_answers.size() != 0) @(posedge clk);
            end
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            send_request(random_request(n < FILL_ITEMS));
        end
        req_valid <= 1'b0;

        // Wait out the last answers, then watch for anything extra.
        while (sb.pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/isr_pkg.sv
design/isr_slot_mem.sv
design/isr_cmp_unit.sv
design/isr_seq.sv
design/id_slot_registry_table_core.sv
bench/tb_id_slot_registry_table_core.sv
